FILE: design/kms_pkg.sv
package kms_pkg;

  localparam int KEY_BITS  = 64;
  localparam int KIDX_W    = 6;
  localparam int KCNT_W    = 7;
  localparam int RC_W      = 3;
  localparam int CODE_W    = 6;
  localparam int GEOM_W    = 4;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int GHOST_MIN = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 2'd3;

  localparam logic [GEOM_W-1:0]  RST_NUM_ROWS    = 4'd4;
  localparam logic [GEOM_W-1:0]  RST_NUM_COLS    = 4'd4;
  localparam logic [DELAY_W-1:0] RST_START_DELAY = 16'd100;
  localparam logic [DELAY_W-1:0] RST_INTERVAL    = 16'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEB,
    ST_SCAN,
    ST_REP,
    ST_FLUSH
  } kms_state_t;

  typedef struct packed {
    logic              valid;
    logic              press;
    logic [CODE_W-1:0] code;
  } held_op_t;

  typedef struct packed {
    logic              emit;
    logic              nonempty;
    logic [CODE_W-1:0] newest;
  } held_stat_t;

endpackage

FILE: design/kms_lane.sv
module kms_lane import kms_pkg::*; #(
  parameter int HISTORY_DEPTH = 4,
  parameter int SLOT_W        = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] slot,
  input  logic              sample,
  input  logic              commit,
  output logic              fresh,
  output logic              changed
);

  logic [HISTORY_DEPTH-1:0] hist_r;
  logic                     deb_r;

  // A key turns on only when every sample shows it and off only when none do.
  assign fresh   = (deb_r | (&hist_r)) & (|hist_r);
  assign changed = fresh ^ deb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      deb_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        for (int j = 0; j < HISTORY_DEPTH; j++) begin
          if (slot == SLOT_W'(j)) begin
            hist_r[j] <= sample;
          end
        end
      end
      if (commit) begin
        deb_r <= fresh;
      end
    end
  end

endmodule

FILE: design/kms_held.sv
module kms_held import kms_pkg::*; #(
  parameter int MAX_HELD = 4,
  parameter int CNT_W    = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  held_op_t   op,
  output held_stat_t stat
);

  logic [CODE_W-1:0] keys_r [MAX_HELD];
  logic [CNT_W-1:0]  count_r;

  logic [CODE_W-1:0] cand [MAX_HELD];
  logic [MAX_HELD-1:0] inuse;
  logic [CNT_W:0]    n_after;
  logic              full;
  logic              ghost;
  logic              has_row;
  logic              has_col;
  logic              found;
  logic [MAX_HELD-1:0] shift_at;
  logic [CODE_W-1:0] newest;

  assign full    = (count_r == CNT_W'(MAX_HELD));
  assign n_after = {1'b0, count_r} + 1'b1;

  always_comb begin
    for (int j = 0; j < MAX_HELD; j++) begin
      cand[j]  = (count_r == CNT_W'(j)) ? op.code : keys_r[j];
      inuse[j] = ((CNT_W+1)'(j) < n_after);
    end
  end

  // Ghost pattern: some held key shares a row with one held key and a
  // column with a held key (the two partners may differ).
  always_comb begin
    ghost = 1'b0;
    for (int a = 0; a < MAX_HELD; a++) begin
      has_row = 1'b0;
      has_col = 1'b0;
      for (int b = 0; b < MAX_HELD; b++) begin
        if (a != b && inuse[b]) begin
          if (cand[a][CODE_W-1:RC_W] == cand[b][CODE_W-1:RC_W]) has_row = 1'b1;
          if (cand[a][RC_W-1:0] == cand[b][RC_W-1:0]) has_col = 1'b1;
        end
      end
      if (inuse[a] && has_row && has_col) ghost = 1'b1;
    end
    if (n_after < (CNT_W+1)'(GHOST_MIN)) ghost = 1'b0;
  end

  // Release: every entry from the first match onward moves down by one.
  always_comb begin
    found = 1'b0;
    for (int j = 0; j < MAX_HELD; j++) begin
      if ((CNT_W'(j) < count_r) && keys_r[j] == op.code) found = 1'b1;
      shift_at[j] = found;
    end
  end

  always_comb begin
    newest = keys_r[0];
    for (int j = 0; j < MAX_HELD; j++) begin
      if (count_r == CNT_W'(j + 1)) newest = keys_r[j];
    end
  end

  assign stat.emit     = op.press ? (!full && !ghost) : found;
  assign stat.nonempty = (count_r != '0);
  assign stat.newest   = newest;

  always_ff @(posedge clk) begin
    if (op.valid && stat.emit) begin
      if (op.press) begin
        for (int j = 0; j < MAX_HELD; j++) begin
          if (count_r == CNT_W'(j)) keys_r[j] <= op.code;
        end
      end else begin
        for (int j = 0; j < MAX_HELD - 1; j++) begin
          if (shift_at[j]) keys_r[j] <= keys_r[j + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op.valid && stat.emit) begin
      if (op.press) begin
        count_r <= count_r + 1'b1;
      end else begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/keypad_matrix_scanner.sv
// Keypad matrix scanner with debounce, ghost-key rejection and auto-repeat.
// Input channel (in_valid/in_ready/in_raw_keys): one item per scan tick, the
// raw key bitmap with bit row*num_cols+col. Output channel (out_*): zero to
// nine key events per scan, in order, with out_last set on the final one.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written by the user
// only while idle; the block does not enforce it. 0 num_rows, 1 num_cols,
// 2 repeat_start_delay, 3 repeat_interval. Each key has its own debounce
// lane; all lanes update together, then a walk visits one key per cycle,
// feeding changed keys to the held list, unless a stalled output holds it.
// An item occupies the block through DEB, SCAN (the key walk), REP and
// FLUSH; in_ready returns high when the last event of the scan sits in the
// output register. A stalled receiver holds the output register and, once
// the one-event pending stage is also full, freezes the key walk at the next
// key with an event until it drains. Reset (rst_n low, synchronous) clears
// history, debounced state, the held list and the configuration to its
// defaults; no sweep follows.
module keypad_matrix_scanner import kms_pkg::*; #(
  parameter int HISTORY_DEPTH = 4,
  parameter int MAX_HELD      = 4,
  parameter int MAX_ROWS      = 8,
  parameter int MAX_COLS      = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_BITS-1:0]  in_raw_keys,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RC_W-1:0]      out_key_row,
  output logic [RC_W-1:0]      out_key_col,
  output logic                 out_released,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_wdata
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_HELD + 1);

  kms_state_t state_r, state_nxt;

  logic [GEOM_W-1:0]  num_rows_r, num_cols_r;
  logic [DELAY_W-1:0] start_delay_r, interval_r;
  logic [GEOM_W-1:0]  rows_eff, cols_eff;
  logic [KCNT_W-1:0]  nkeys;

  logic [SLOT_W-1:0]   slot_r;
  logic [KEY_BITS-1:0] mask;
  logic [KEY_BITS-1:0] fresh_w, chg_w;
  logic [KEY_BITS-1:0] fresh_r, changed_r;
  logic [KCNT_W-1:0]   idx_r;
  logic [RC_W-1:0]     row_r, col_r;
  logic [DELAY_W-1:0]  cd_r;

  logic            pend_v_r, pend_rel_r;
  logic [RC_W-1:0] pend_row_r, pend_col_r;
  logic            out_valid_r, out_rel_r, out_last_r;
  logic [RC_W-1:0] out_row_r, out_col_r;

  logic            in_fire, can_push, key_live, act, ev_here, rep_fire;
  logic            step, op_go, rep_go, flush_go, push;
  logic            new_ev, new_rel;
  logic [RC_W-1:0] new_row, new_col;
  held_op_t        op;
  held_stat_t      stat;

  always_comb begin
    if (num_rows_r == '0) rows_eff = GEOM_W'(1);
    else if (num_rows_r > GEOM_W'(MAX_ROWS)) rows_eff = GEOM_W'(MAX_ROWS);
    else rows_eff = num_rows_r;
    if (num_cols_r == '0) cols_eff = GEOM_W'(1);
    else if (num_cols_r > GEOM_W'(MAX_COLS)) cols_eff = GEOM_W'(MAX_COLS);
    else cols_eff = num_cols_r;
  end

  // Widen before multiplying so that an 8 by 8 matrix gives 64.
  assign nkeys = KCNT_W'(rows_eff) * KCNT_W'(cols_eff);

  always_comb begin
    for (int i = 0; i < KEY_BITS; i++) begin
      mask[i] = (KCNT_W'(i) < nkeys);
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign can_push = !out_valid_r || out_ready;

  genvar g;
  generate
    for (g = 0; g < KEY_BITS; g++) begin : g_lane
      kms_lane #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SLOT_W(SLOT_W)
      ) u_lane (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(in_fire),
        .slot(slot_r),
        .sample(in_raw_keys[g] & mask[g]),
        .commit(state_r == ST_DEB),
        .fresh(fresh_w[g]),
        .changed(chg_w[g])
      );
    end
  endgenerate

  kms_held #(
    .MAX_HELD(MAX_HELD),
    .CNT_W(CNT_W)
  ) u_held (
    .clk(clk),
    .rst_n(rst_n),
    .op(op),
    .stat(stat)
  );

  assign key_live = (idx_r < nkeys);
  assign act      = key_live && changed_r[idx_r[KIDX_W-1:0]];
  assign rep_fire = stat.nonempty && (cd_r == '0);

  always_comb begin
    op.valid = op_go;
    op.press = fresh_r[idx_r[KIDX_W-1:0]];
    op.code  = {row_r, col_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_DEB;
      ST_DEB:   state_nxt = ST_SCAN;
      ST_SCAN:  if (!key_live) state_nxt = ST_REP;
      ST_REP:   if (rep_go) state_nxt = ST_FLUSH;
      ST_FLUSH: if (flush_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // A new event may only enter the pending stage if the item already there
  // can move into the output register in the same cycle.
  always_comb begin
    in_ready = 1'b0;
    ev_here  = 1'b0;
    step     = 1'b0;
    op_go    = 1'b0;
    rep_go   = 1'b0;
    flush_go = 1'b0;
    new_ev   = 1'b0;
    new_row  = row_r;
    new_col  = col_r;
    new_rel  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        ev_here = act && stat.emit;
        if (key_live && !(ev_here && pend_v_r && !can_push)) step = 1'b1;
        op_go   = act && step;
        new_ev  = ev_here && step;
        new_rel = !op.press;
      end
      ST_REP: begin
        rep_go  = !(rep_fire && pend_v_r && !can_push);
        new_ev  = rep_fire && rep_go;
        new_row = stat.newest[CODE_W-1:RC_W];
        new_col = stat.newest[RC_W-1:0];
      end
      ST_FLUSH: begin
        flush_go = !pend_v_r || can_push;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign push = pend_v_r && ((new_ev) || (state_r == ST_FLUSH && flush_go));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_rows_r    <= RST_NUM_ROWS;
      num_cols_r    <= RST_NUM_COLS;
      start_delay_r <= RST_START_DELAY;
      interval_r    <= RST_INTERVAL;
      slot_r        <= '0;
      idx_r         <= '0;
      row_r         <= '0;
      col_r         <= '0;
      cd_r          <= RST_START_DELAY;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS:    num_rows_r    <= cfg_wdata[GEOM_W-1:0];
          REG_NUM_COLS:    num_cols_r    <= cfg_wdata[GEOM_W-1:0];
          REG_START_DELAY: start_delay_r <= cfg_wdata;
          REG_INTERVAL:    interval_r    <= cfg_wdata;
          default:         interval_r    <= interval_r;
        endcase
      end
      if (in_fire) begin
        slot_r <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        idx_r  <= '0;
        row_r  <= '0;
        col_r  <= '0;
      end else if (step) begin
        idx_r <= idx_r + 1'b1;
        if ({1'b0, col_r} == cols_eff - 1'b1) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (op_go && op.press && stat.emit) begin
        cd_r <= start_delay_r;
      end else if (state_r == ST_REP && rep_go) begin
        if (!stat.nonempty) cd_r <= start_delay_r;
        else if (cd_r == '0) cd_r <= interval_r;
        else cd_r <= cd_r - 1'b1;
      end
      if (new_ev) begin
        pend_v_r <= 1'b1;
      end else if (push) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DEB) begin
      fresh_r   <= fresh_w;
      changed_r <= chg_w;
    end
    if (new_ev) begin
      pend_row_r <= new_row;
      pend_col_r <= new_col;
      pend_rel_r <= new_rel;
    end
    if (push) begin
      out_row_r  <= pend_row_r;
      out_col_r  <= pend_col_r;
      out_rel_r  <= pend_rel_r;
      out_last_r <= (state_r == ST_FLUSH);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_row  = out_row_r;
  assign out_key_col  = out_col_r;
  assign out_released = out_rel_r;
  assign out_last     = out_last_r;

endmodule

FILE: design/kms_checker.sv
module kms_checker import kms_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [RC_W-1:0]      out_key_row,
  input logic [RC_W-1:0]      out_key_col,
  input logic                 out_released,
  input logic                 out_last
);

  // Once an item is accepted, in_ready stays low while the scan begins.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("next item accepted too early");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // While a non-final event waits at the output, the scanner is not idle.
  a_last_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("scan ended without a final event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_row)
      && $stable(out_key_col) && $stable(out_released) && $stable(out_last))
    else $error("stalled output changed");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_key_row(out_key_row),
  .out_key_col(out_key_col),
  .out_released(out_released),
  .out_last(out_last)
);
